>>> src/kdfe_pkg.sv
// package: shared types, constants and phase codes for the keyed decimal field extractor
`timescale 1ns / 1ps

package kdfe_pkg;

  // sizing
  localparam int unsigned MAX_VALUE_LEN = 20;
  localparam int unsigned MAX_KEY_LEN   = 8;
  localparam int unsigned VAL_LEN_W     = $clog2(MAX_VALUE_LEN);
  localparam int unsigned KEY_LEN_W     = 4;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 1'b1;

  // parse phase codes
  localparam logic [2:0] PH_WAIT_FIRST = 3'd0;
  localparam logic [2:0] PH_WAIT_REST  = 3'd1;
  localparam logic [2:0] PH_RECORD     = 3'd2;
  localparam logic [2:0] PH_DONE       = 3'd3;
  localparam logic [2:0] PH_ERROR      = 3'd4;

  // character codes
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] value;
  } out_item_t;

  typedef struct packed {
    logic [2:0]           phase;
    logic [KEY_LEN_W-1:0] match_pos;
    logic [VAL_LEN_W-1:0] val_len;
    logic [31:0]          acc;
    logic                 bad_digit;
  } parse_state_t;

endpackage

>>> src/kdfe_step.sv
// per-byte parse step: next parse state and the result for a final byte
`timescale 1ns / 1ps

module kdfe_step (
  input  kdfe_pkg::parse_state_t         state_i,
  input  kdfe_pkg::in_item_t             item_i,
  input  logic [63:0]                    key_pattern_i,
  input  logic [kdfe_pkg::KEY_LEN_W-1:0] key_length_i,
  output kdfe_pkg::parse_state_t         state_o,
  output kdfe_pkg::out_item_t            result_o
);

  logic [kdfe_pkg::KEY_LEN_W-1:0] eff_len;
  logic [7:0]                     key_byte;
  logic [7:0]                     b;
  logic                           is_digit;
  logic [31:0]                    acc_x10;
  kdfe_pkg::parse_state_t         nxt;

  assign b = item_i.text_byte;

  // effective key length, clamped to 1..MAX_KEY_LEN
  always_comb begin
    eff_len = key_length_i;
    if (key_length_i == '0) begin
      eff_len = kdfe_pkg::KEY_LEN_W'(1);
    end else if (key_length_i > kdfe_pkg::KEY_LEN_W'(kdfe_pkg::MAX_KEY_LEN)) begin
      eff_len = kdfe_pkg::KEY_LEN_W'(kdfe_pkg::MAX_KEY_LEN);
    end
  end

  // key byte at the current match position
  assign key_byte = key_pattern_i[{state_i.match_pos[2:0], 3'b000} +: 8];

  // decimal fold
  assign is_digit = (b >= kdfe_pkg::CHAR_ZERO) && (b <= kdfe_pkg::CHAR_NINE);
  assign acc_x10  = {state_i.acc[28:0], 3'b000} + {state_i.acc[30:0], 1'b0};

  // phase transitions
  always_comb begin
    nxt = state_i;
    case (state_i.phase)
      kdfe_pkg::PH_WAIT_FIRST: begin
        if (b == key_pattern_i[7:0]) begin
          nxt.match_pos = kdfe_pkg::KEY_LEN_W'(1);
          nxt.phase     = kdfe_pkg::PH_WAIT_REST;
        end
      end
      kdfe_pkg::PH_WAIT_REST: begin
        if (state_i.match_pos < eff_len) begin
          if (b == key_byte) begin
            nxt.match_pos = state_i.match_pos + kdfe_pkg::KEY_LEN_W'(1);
          end else begin
            nxt.match_pos = '0;
            nxt.phase     = kdfe_pkg::PH_WAIT_FIRST;
          end
        end else begin
          // byte after the key is skipped
          nxt.phase = kdfe_pkg::PH_RECORD;
        end
      end
      kdfe_pkg::PH_RECORD: begin
        if (b == kdfe_pkg::CHAR_QUOTE) begin
          nxt.phase = (state_i.val_len == '0) ? kdfe_pkg::PH_ERROR : kdfe_pkg::PH_DONE;
        end else if (state_i.val_len >=
                     kdfe_pkg::VAL_LEN_W'(kdfe_pkg::MAX_VALUE_LEN - 1)) begin
          nxt.phase = kdfe_pkg::PH_ERROR;
        end else begin
          if (is_digit) begin
            nxt.acc = acc_x10 + {24'd0, b - kdfe_pkg::CHAR_ZERO};
          end else if (!(b == kdfe_pkg::CHAR_NUL && state_i.val_len != '0)) begin
            nxt.bad_digit = 1'b1;
          end
          nxt.val_len = state_i.val_len + kdfe_pkg::VAL_LEN_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result and restart on the final byte
  always_comb begin
    if (nxt.phase == kdfe_pkg::PH_DONE && !nxt.bad_digit) begin
      result_o.status = kdfe_pkg::STATUS_OK;
      result_o.value  = nxt.acc;
    end else begin
      result_o.status = kdfe_pkg::STATUS_ERR;
      result_o.value  = '0;
    end
    state_o = nxt;
    if (item_i.last_byte) begin
      state_o.phase     = kdfe_pkg::PH_WAIT_FIRST;
      state_o.match_pos = '0;
      state_o.val_len   = '0;
      state_o.acc       = '0;
      state_o.bad_digit = 1'b0;
    end
  end

endmodule

>>> src/keyed_decimal_field_extractor_unit.sv
// top level: input register, parse state, result register and config registers
//
// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o   in_i  (text_byte, last_byte)
// out       source     out_valid_o / out_stall_i out_o (status, value)
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one byte per cycle sustained while no final byte is held; a byte is parsed
// from the input register, and a result is then loaded into the result register
// reset clears parse state, config registers (key 0, length 1) and both valid flags
// a final byte waits in the input register while an earlier result is stalled;
// other bytes keep flowing under an output stall
`timescale 1ns / 1ps

module keyed_decimal_field_extractor_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  kdfe_pkg::in_item_t                  in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output kdfe_pkg::out_item_t                 out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kdfe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [kdfe_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [63:0]                    key_pattern_q;
  logic [kdfe_pkg::KEY_LEN_W-1:0] key_length_q;
  logic                           in_valid_q;
  kdfe_pkg::in_item_t             in_q;
  kdfe_pkg::parse_state_t         state_q;
  kdfe_pkg::parse_state_t         state_d;
  logic                           out_valid_q;
  kdfe_pkg::out_item_t            out_q;
  kdfe_pkg::out_item_t            result;
  logic                           proc;
  logic                           in_take;

  // config writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_pattern_q <= '0;
      key_length_q  <= kdfe_pkg::KEY_LEN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        kdfe_pkg::REG_KEY_PATTERN: key_pattern_q <= cfg_data_i[63:0];
        kdfe_pkg::REG_KEY_LENGTH:  key_length_q  <= cfg_data_i[kdfe_pkg::KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a held beat is parsed unless it is final and the result slot stays full
  assign proc       = in_valid_q && (!in_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i;
    end
  end

  // parse step
  kdfe_step u_step (
    .state_i       (state_q),
    .item_i        (in_q),
    .key_pattern_i (key_pattern_q),
    .key_length_i  (key_length_q),
    .state_o       (state_d),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: kdfe_pkg::PH_WAIT_FIRST, match_pos: '0, val_len: '0,
                   acc: '0, bad_digit: 1'b0};
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && in_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_q.last_byte) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // checks
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == kdfe_pkg::STATUS_ERR) |-> out_o.value == '0)
    else $error("error result carries a nonzero value");

  a_final_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.last_byte |=> out_valid_q)
    else $error("final beat did not load a result");

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.last_byte |=> state_q.phase == kdfe_pkg::PH_WAIT_FIRST &&
                               state_q.val_len == '0)
    else $error("parse state not cleared after final beat");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.val_len <= kdfe_pkg::VAL_LEN_W'(kdfe_pkg::MAX_VALUE_LEN - 1))
    else $error("value length past its limit");

endmodule
